[rtl/twi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_pkg: shared types and constants
// word layouts, bus commands and bus status codes for the sequencer
// ----------------------------------------------------------------------------
package twi_pkg;

	// bus command issued back to the controller
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_SEND  = 3'd2,
		CMD_STOP  = 3'd3,
		CMD_ACK   = 3'd4,
		CMD_NACK  = 3'd5,
		CMD_RESET = 3'd6
	} cmd_t;

	// operation codes of an input word
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_EVENT = 1'b1;

	// status register, low three bits ignored
	localparam logic [7:0] STATUS_MASK         = 8'hF8;
	localparam logic [7:0] ST_START            = 8'h08;
	localparam logic [7:0] ST_RESTART          = 8'h10;
	localparam logic [7:0] ST_MT_SLA_ACK       = 8'h18;
	localparam logic [7:0] ST_MT_SLA_NACK      = 8'h20;
	localparam logic [7:0] ST_MT_DATA_ACK      = 8'h28;
	localparam logic [7:0] ST_MT_DATA_NACK     = 8'h30;
	localparam logic [7:0] ST_ARB_LOST         = 8'h38;
	localparam logic [7:0] ST_SR_SLA_ACK       = 8'h60;
	localparam logic [7:0] ST_SR_ARB_SLA_ACK   = 8'h68;
	localparam logic [7:0] ST_SR_GCALL_ACK     = 8'h70;
	localparam logic [7:0] ST_SR_ARB_GCALL_ACK = 8'h78;
	localparam logic [7:0] ST_SR_DATA_ACK      = 8'h80;
	localparam logic [7:0] ST_SR_DATA_NACK     = 8'h88;
	localparam logic [7:0] ST_SR_GC_DATA_ACK   = 8'h90;
	localparam logic [7:0] ST_SR_GC_DATA_NACK  = 8'h98;
	localparam logic [7:0] ST_SR_STOP          = 8'hA0;

	typedef struct packed {
		logic       operation;
		logic [7:0] target_address;
		logic [7:0] request_byte;
		logic       request_last;
		logic [7:0] status_code;
		logic [7:0] received_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] transmit_byte;
		logic       accepted;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic [3:0] rx_index;
		logic       message_done;
		logic [4:0] message_length;
		logic       overflow;
	} out_item_t;

	// first stage: decoded result, transmit byte may still come from the buffer ram
	typedef struct packed {
		out_item_t res;
		logic      tx_from_ram;
	} stage_t;

endpackage
`default_nettype wire

[rtl/twi_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_req_if: input channel
// valid/ready channel carrying one request or status word
// ----------------------------------------------------------------------------
interface twi_req_if;
	import twi_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/twi_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_rsp_if: result channel
// valid/ready channel carrying one result word
// ----------------------------------------------------------------------------
interface twi_rsp_if;
	import twi_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/twi_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_ram: generic simple dual-port ram
// one write port, one read port with enable and registered read data
// ----------------------------------------------------------------------------
module twi_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/twi_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_ctrl: status decode and sequencing state
// decodes each accepted word, updates counters, drives the buffer ram
// ----------------------------------------------------------------------------
module twi_ctrl #(
	parameter int BUFFER_DEPTH = 16,
	parameter int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire twi_pkg::in_item_t item,
	input  wire logic              advance,
	output logic                   s1_valid,
	output twi_pkg::stage_t        s1,
	output logic                   ram_we,
	output logic      [ADDR_W-1:0] ram_waddr,
	output logic      [7:0]        ram_wdata,
	output logic                   ram_re,
	output logic      [ADDR_W-1:0] ram_raddr
);
	import twi_pkg::*;

	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

	logic [7:0]       addr_hold_q, addr_hold_d;
	logic [CNT_W-1:0] tx_count_q, tx_count_d;
	logic [CNT_W-1:0] tx_pos_q, tx_pos_d;
	logic             busy_q, busy_d;
	logic [CNT_W-1:0] rx_count_q, rx_count_d;
	logic             s1_valid_q;
	stage_t           s1_d, s1_s1;
	logic [7:0]       code;

	assign code = item.status_code & STATUS_MASK;

	always_comb begin
		addr_hold_d = addr_hold_q;
		tx_count_d  = tx_count_q;
		tx_pos_d    = tx_pos_q;
		busy_d      = busy_q;
		rx_count_d  = rx_count_q;
		s1_d        = '0;
		ram_we      = 1'b0;
		ram_waddr   = tx_count_q[ADDR_W-1:0];
		ram_wdata   = item.request_byte;
		ram_re      = 1'b0;
		ram_raddr   = tx_pos_q[ADDR_W-1:0];

		if (item.operation == OP_LOAD) begin
			if (!busy_q) begin
				addr_hold_d = item.target_address;
				if (tx_count_q < DEPTH_C) begin
					ram_we            = accept;
					tx_count_d        = tx_count_q + 1'b1;
					s1_d.res.accepted = 1'b1;
				end else begin
					s1_d.res.overflow = 1'b1;
				end
				if (item.request_last) begin
					tx_pos_d         = '0;
					busy_d           = 1'b1;
					s1_d.res.command = CMD_START;
				end
			end
		end else begin
			case (code)
				ST_START, ST_RESTART: begin
					s1_d.res.transmit_byte = addr_hold_q;
					s1_d.res.command       = CMD_SEND;
				end
				ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
					if (tx_pos_q < tx_count_q && tx_pos_q < DEPTH_C) begin
						// next byte comes out of the buffer ram's registered read port
						ram_re           = accept;
						s1_d.tx_from_ram = 1'b1;
						tx_pos_d         = tx_pos_q + 1'b1;
						s1_d.res.command = CMD_SEND;
					end else begin
						tx_pos_d         = '0;
						tx_count_d       = '0;
						busy_d           = 1'b0;
						s1_d.res.command = CMD_STOP;
					end
				end
				ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_ARB_LOST: begin
					s1_d.res.command = CMD_START;
				end
				ST_SR_SLA_ACK, ST_SR_ARB_SLA_ACK, ST_SR_GCALL_ACK: begin
					s1_d.res.command = CMD_ACK;
				end
				ST_SR_ARB_GCALL_ACK, ST_SR_DATA_NACK, ST_SR_GC_DATA_NACK: begin
					s1_d.res.command = CMD_NACK;
				end
				ST_SR_DATA_ACK, ST_SR_GC_DATA_ACK: begin
					if (rx_count_q < DEPTH_C) begin
						s1_d.res.rx_valid = 1'b1;
						s1_d.res.rx_data  = item.received_byte;
						s1_d.res.rx_index = 4'(rx_count_q);
						rx_count_d        = rx_count_q + 1'b1;
					end else begin
						s1_d.res.overflow = 1'b1;
					end
					s1_d.res.command = CMD_ACK;
				end
				ST_SR_STOP: begin
					s1_d.res.command        = CMD_RESET;
					s1_d.res.message_done   = 1'b1;
					s1_d.res.message_length = 5'(rx_count_q);
					rx_count_d              = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_hold_q <= '0;
			tx_count_q  <= '0;
			tx_pos_q    <= '0;
			busy_q      <= 1'b0;
			rx_count_q  <= '0;
			s1_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				addr_hold_q <= addr_hold_d;
				tx_count_q  <= tx_count_d;
				tx_pos_q    <= tx_pos_d;
				busy_q      <= busy_d;
				rx_count_q  <= rx_count_d;
				s1_valid_q  <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1 <= s1_d;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1       = s1_s1;
endmodule
`default_nettype wire

[rtl/twi_master_tx_slave_rx_sequencer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// an accepted word passes through the first stage register and the result register before it is offered
// throughput: one word per cycle, stalling only while both stages are full and rsp.ready is low
// the result register lets a new word enter while a finished result waits
// reset: arst_n clears counters, busy flag, held address and both valid flags
// the transmit buffer ram is not cleared; only written entries are ever read
// ----------------------------------------------------------------------------
// twi_master_tx_slave_rx_sequencer_top: two-wire bus software sequencer
// master transmit and slave receive handling of bus status events
// ----------------------------------------------------------------------------
module twi_master_tx_slave_rx_sequencer_top #(
	parameter int BUFFER_DEPTH = 16
) (
	input wire logic    clk,
	input wire logic    arst_n,
	twi_req_if.sink     req,
	twi_rsp_if.source   rsp
);
	import twi_pkg::*;

	localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	// pipeline handshake
	logic              accept;
	logic              s1_valid;
	logic              s1_adv;
	stage_t            s1;

	// buffer ram ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	// result register
	logic              out_valid_q;
	out_item_t         out_q;
	out_item_t         out_d;

	// first stage moves on when the result register is empty or being drained
	assign s1_adv    = s1_valid && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid || s1_adv;
	assign accept    = req.valid && req.ready;

	twi_ctrl #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.ADDR_W       (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (req.data),
		.advance   (s1_adv),
		.s1_valid  (s1_valid),
		.s1        (s1),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	// transmit buffer; read data holds until the next send is accepted
	twi_ram #(
		.WIDTH  (8),
		.DEPTH  (BUFFER_DEPTH),
		.ADDR_W (ADDR_W)
	) u_tx_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// merge the buffered byte into the decoded result
	always_comb begin
		out_d = s1.res;
		if (s1.tx_from_ram) begin
			out_d.transmit_byte = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
endmodule
`default_nettype wire
